// ===== sv/adnp_pkg.sv =====
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared widths, register indexes, reset values and types for the PCM
// decimator and nibble packer.
// ----------------------------------------------------------------------------
package adnp_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 31;
    localparam int RATE_BITS = 18;
    localparam int PHASE_W   = RATE_BITS + 2;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int NIB_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEREO   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_IN_RATE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE = CFG_IDX_W'(3);

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Register reset values
    localparam int GAIN_RST     = 65536;
    localparam int IN_RATE_RST  = 44100;
    localparam int OUT_RATE_RST = 8000;
    localparam logic signed [PHASE_W-1:0] PHASE_RST = PHASE_W'(-IN_RATE_RST);

    // Quantizer: offset of 8.0 in Q4.28 (half the nibble range), nibble lives at bits 31:28
    localparam int QUANT_SHIFT = 28;
    localparam logic [NIB_W-1:0]  NIB_MAX  = 4'hF;
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h88;

    typedef struct packed {
        logic                 stereo;
        logic [GAIN_W-1:0]    gain;
        logic [RATE_BITS-1:0] in_rate;
        logic [RATE_BITS-1:0] out_rate;
    } cfg_t;

    // Control from the input stage to the rate accumulator
    typedef struct packed {
        logic                 step;
        logic                 finish;
        logic                 load;
        logic [RATE_BITS-1:0] load_rate;
    } phase_ctl_t;

    // Token handed to the pack stage
    typedef struct packed {
        logic                     finish;
        logic signed [PROD_W-1:0] prod;
    } tok_t;

endpackage

// ===== sv/adnp_if.sv =====
// ----------------------------------------------------------------------------
// adnp channel interfaces
// Valid/ready channels for PCM sample requests and packed byte results.
// ----------------------------------------------------------------------------
interface adnp_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic signed [adnp_pkg::SAMPLE_W-1:0]  left_sample;
    logic signed [adnp_pkg::SAMPLE_W-1:0]  right_sample;

    modport source (output valid, output cmd, output left_sample, output right_sample,
                    input ready);
    modport sink   (input valid, input cmd, input left_sample, input right_sample,
                    output ready);
endinterface

interface adnp_out_if;
    logic                        valid;
    logic                        ready;
    logic [adnp_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== sv/adnp_phase.sv =====
// ----------------------------------------------------------------------------
// adnp_phase
// Saturating rate accumulator that decides which samples are kept.
// ----------------------------------------------------------------------------
module adnp_phase
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  adnp_pkg::cfg_t       cfg,
    input  adnp_pkg::phase_ctl_t ctl,
    output logic                 keep
);

    localparam int PW = adnp_pkg::PHASE_W;

    logic signed [PW-1:0] phase_reg;
    logic signed [PW-1:0] phase_next;
    logic signed [PW:0]   sum_add;
    logic signed [PW:0]   sum_sub;
    logic signed [PW-1:0] sat_add;
    logic signed [PW-1:0] sat_sub;
    logic signed [PW-1:0] neg_in_rate;
    logic signed [PW-1:0] neg_load_rate;

    // Clamp a one-bit-wider sum into the phase range
    function automatic logic signed [PW-1:0] sat_phase(input logic signed [PW:0] v);
        logic signed [PW-1:0] r;
        if (v[PW] != v[PW-1])
        begin
            r = v[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        else
        begin
            r = v[PW-1:0];
        end
        return r;
    endfunction

    // Add out_rate, keep when positive, then take off in_rate
    always_comb
    begin
        sum_add       = $signed({phase_reg[PW-1], phase_reg})
                        + $signed({3'b000, cfg.out_rate});
        sat_add       = sat_phase(sum_add);
        keep          = !sat_add[PW-1] && (|sat_add);
        sum_sub       = $signed({sat_add[PW-1], sat_add})
                        - $signed({3'b000, cfg.in_rate});
        sat_sub       = sat_phase(sum_sub);
        neg_in_rate   = -$signed({2'b00, cfg.in_rate});
        neg_load_rate = -$signed({2'b00, ctl.load_rate});
    end

    // Select the next phase: reload on in_rate write, restart on finish, else advance on a step
    always_comb
    begin
        phase_next = phase_reg;
        priority if (ctl.load)
        begin
            phase_next = neg_load_rate;
        end
        else if (ctl.step && ctl.finish)
        begin
            phase_next = neg_in_rate;
        end
        else if (ctl.step)
        begin
            phase_next = keep ? sat_sub : sat_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= adnp_pkg::PHASE_RST;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/adnp_pack.sv =====
// ----------------------------------------------------------------------------
// adnp_pack
// Quantizes scaled samples to nibbles, packs them into bytes and drains the
// flush sequence into the output register.
// ----------------------------------------------------------------------------
module adnp_pack
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  adnp_pkg::tok_t    tok,
    output logic              tok_consume,
    adnp_out_if.source        out_ch
);

    localparam int NW = adnp_pkg::PROD_W + 1;
    localparam int QS = adnp_pkg::QUANT_SHIFT;

    logic [adnp_pkg::NIB_W-1:0]  held_reg;
    logic [adnp_pkg::NIB_W-1:0]  held_next;
    logic                        pending_reg;
    logic                        pending_next;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  cnt_next;
    logic                        out_valid_reg;
    logic [adnp_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        out_last_reg;

    logic signed [NW-1:0]        num;
    logic [adnp_pkg::NIB_W-1:0]  nib;
    logic                        out_free;
    logic                        emit;
    logic                        final_step;
    logic                        go;
    logic [adnp_pkg::BYTE_W-1:0] emit_byte;
    logic                        emit_last;

    // Offset by one half and clamp the top nibble to 0..15
    always_comb
    begin
        num = $signed({tok.prod[adnp_pkg::PROD_W-1], tok.prod})
              + $signed(NW'(64'd1 << (QS + 3)));
        priority if (num[NW-1] || (num == '0))
        begin
            nib = '0;
        end
        else if (|num[NW-2:QS+adnp_pkg::NIB_W])
        begin
            nib = adnp_pkg::NIB_MAX;
        end
        else
        begin
            nib = num[QS+adnp_pkg::NIB_W-1:QS];
        end
    end

    // Decide this cycle's byte and whether the token is done
    always_comb
    begin
        emit       = 1'b0;
        final_step = 1'b1;
        emit_byte  = adnp_pkg::PAD_BYTE;
        emit_last  = 1'b1;
        if (tok.finish == adnp_pkg::CMD_SAMPLE)
        begin
            emit      = pending_reg;
            emit_byte = {held_reg, nib};
        end
        else if (pending_reg)
        begin
            emit       = 1'b1;
            emit_byte  = {held_reg, held_reg};
            emit_last  = (cnt_reg == 2'd3);
            final_step = emit_last;
        end
        else if (cnt_reg != 2'd0)
        begin
            emit       = 1'b1;
            emit_last  = (cnt_reg == 2'd3);
            final_step = emit_last;
        end
    end

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign go          = tok_valid && (!emit || out_free);
    assign tok_consume = go && final_step;

    // Advance the pack state
    always_comb
    begin
        held_next    = held_reg;
        pending_next = pending_reg;
        cnt_next     = cnt_reg;
        if (go)
        begin
            if (tok.finish == adnp_pkg::CMD_FINISH && final_step)
            begin
                held_next    = '0;
                pending_next = 1'b0;
                cnt_next     = 2'd0;
            end
            else if (tok.finish == adnp_pkg::CMD_FINISH)
            begin
                pending_next = 1'b0;
                cnt_next     = cnt_reg + 2'd1;
            end
            else if (pending_reg)
            begin
                pending_next = 1'b0;
                cnt_next     = cnt_reg + 2'd1;
            end
            else
            begin
                held_next    = nib;
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            pending_reg   <= 1'b0;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg    <= held_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
            if (go && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;

endmodule

// ===== sv/audio_decimate_nibble_pack.sv =====
// ----------------------------------------------------------------------------
// audio_decimate_nibble_pack
// Decimates 16-bit PCM, scales and quantizes to 4-bit nibbles, packs bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: cmd 0 with a left (and right) sample, or cmd 1 to
//   finish the stream. out_ch returns packed bytes; last marks the final byte
//   caused by one request. Registers are written through cfg_we, cfg_index and
//   cfg_data; the user must do so only while the block is idle (not enforced).
// Timing:
//   One request per cycle while in_ch.ready is high. A sample passes an input
//   stage, the gain multiplier register and the pack stage, in that order. A
//   finish request emits up to 4 bytes, one per cycle from the pack stage
//   while out_ch is ready, and holds that stage until its last byte is out;
//   the earlier stages keep taking requests until they fill.
// Reset:
//   rst_n clears registers to their defaults, the rate phase to -in_rate
//   and empties all stages. No clearing pass is needed.
// Stall:
//   When out_ch is not ready the result register holds its byte and the
//   stages behind it fill up, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module audio_decimate_nibble_pack
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [adnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adnp_pkg::CFG_W-1:0]        cfg_data,
    adnp_in_if.sink                           in_ch,
    adnp_out_if.source                        out_ch
);

    localparam int SW = adnp_pkg::SAMPLE_W;

    adnp_pkg::cfg_t       cfg_reg;
    adnp_pkg::phase_ctl_t phase_ctl;
    adnp_pkg::tok_t       tok;

    logic                         keep;
    logic                         in_fire;
    logic                         a_take;
    logic                         b_take;
    logic                         consume;

    logic                         a_valid_reg;
    logic                         a_fin_reg;
    logic signed [SW-1:0]         a_s_reg;
    logic                         b_valid_reg;
    logic                         b_fin_reg;
    logic signed [adnp_pkg::PROD_W-1:0] b_prod_reg;

    logic signed [SW:0]           pair_sum;
    logic signed [SW:0]           pair_avg;
    logic signed [SW-1:0]         sample;
    logic signed [2*SW-1+adnp_pkg::GAIN_W-SW+1:0] mult_full;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stereo   <= 1'b0;
            cfg_reg.gain     <= adnp_pkg::GAIN_W'(adnp_pkg::GAIN_RST);
            cfg_reg.in_rate  <= adnp_pkg::RATE_BITS'(adnp_pkg::IN_RATE_RST);
            cfg_reg.out_rate <= adnp_pkg::RATE_BITS'(adnp_pkg::OUT_RATE_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adnp_pkg::REG_STEREO:   cfg_reg.stereo   <= cfg_data[0];
                adnp_pkg::REG_GAIN:     cfg_reg.gain     <= cfg_data[adnp_pkg::GAIN_W-1:0];
                adnp_pkg::REG_IN_RATE:  cfg_reg.in_rate  <= cfg_data[adnp_pkg::RATE_BITS-1:0];
                adnp_pkg::REG_OUT_RATE: cfg_reg.out_rate <= cfg_data[adnp_pkg::RATE_BITS-1:0];
                default:                cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Stage handshakes: each stage loads when empty or when drained
    assign b_take      = !b_valid_reg || consume;
    assign a_take      = !a_valid_reg || b_take;
    assign in_ch.ready = a_take;
    assign in_fire     = in_ch.valid && a_take;

    // Average left and right, truncating toward zero
    always_comb
    begin
        pair_sum = $signed({in_ch.left_sample[SW-1], in_ch.left_sample})
                   + $signed({in_ch.right_sample[SW-1], in_ch.right_sample});
        pair_avg = (pair_sum + $signed({{SW{1'b0}}, pair_sum[SW]})) >>> 1;
        sample   = cfg_reg.stereo ? pair_avg[SW-1:0] : in_ch.left_sample;
    end

    // Drive the rate accumulator
    always_comb
    begin
        phase_ctl.step      = in_fire;
        phase_ctl.finish    = (in_ch.cmd == adnp_pkg::CMD_FINISH);
        phase_ctl.load      = cfg_we && (cfg_index == adnp_pkg::REG_IN_RATE);
        phase_ctl.load_rate = cfg_data[adnp_pkg::RATE_BITS-1:0];
    end

    adnp_phase u_phase
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (phase_ctl),
        .keep  (keep)
    );

    // Input stage: hold kept samples and finish requests, drop the rest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_take)
        begin
            a_valid_reg <= in_fire && ((in_ch.cmd == adnp_pkg::CMD_FINISH) || keep);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_fin_reg <= (in_ch.cmd == adnp_pkg::CMD_FINISH);
            a_s_reg   <= sample;
        end
    end

    // Gain multiply stage
    assign mult_full = a_s_reg * $signed({1'b0, cfg_reg.gain});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_take)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_take && a_valid_reg)
        begin
            b_fin_reg  <= a_fin_reg;
            b_prod_reg <= mult_full[adnp_pkg::PROD_W-1:0];
        end
    end

    // Quantize, pack and flush
    always_comb
    begin
        tok.finish = b_fin_reg;
        tok.prod   = b_prod_reg;
    end

    adnp_pack u_pack
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (b_valid_reg),
        .tok         (tok),
        .tok_consume (consume),
        .out_ch      (out_ch)
    );

`ifndef SYNTH
    // A byte that is not last comes from a flush: doubled nibble or pad
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last) |-> (out_ch.out_byte[7:4] == out_ch.out_byte[3:0]))
        else $error("non-last byte is not a flush byte");

    // A flush never pauses between its bytes once the receiver takes one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
        else $error("flush sequence broken after non-last byte");

    // The pack stage only releases a token when the stage behind is full
    assert property (@(posedge clk) disable iff (!rst_n)
        consume |-> b_valid_reg)
        else $error("pack stage consumed an empty slot");
`endif

endmodule

// ===== bench/audio_decimate_nibble_pack_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_decimate_nibble_pack_test
// Drives PCM sample and finish requests into the decimating nibble packer
// and checks every packed byte against a cycle-free model of the rate
// accumulator, gain quantizer, byte packer and finish padding. Both channels
// idle at random in some phases, and registers are rewritten between drained phases.
// ----------------------------------------------------------------------------
module audio_decimate_nibble_pack_test;

    localparam logic [adnp_pkg::CFG_IDX_W-1:0] REG_UNUSED = adnp_pkg::CFG_IDX_W'(12);
    localparam logic [adnp_pkg::GAIN_W-1:0]    GAIN_MAX   = '1;
    localparam logic [adnp_pkg::RATE_BITS-1:0] RATE_MAX   = '1;
    localparam longint PH_MAX = (longint'(1) << (adnp_pkg::PHASE_W - 1)) - 1;
    localparam longint PH_MIN = -PH_MAX - 1;

    typedef struct {
        logic                                 cmd;
        logic signed [adnp_pkg::SAMPLE_W-1:0] lsmp;
        logic signed [adnp_pkg::SAMPLE_W-1:0] rsmp;
    } pcm_req_t;

    typedef struct {
        logic [adnp_pkg::BYTE_W-1:0] data;
        logic                        last;
    } packed_byte_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [adnp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [adnp_pkg::CFG_W-1:0]     cfg_data;

    adnp_in_if  in_ch ();
    adnp_out_if out_ch ();

    audio_decimate_nibble_pack dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Register shadows and packer state of the model
    logic                           stereo_sh;
    logic [adnp_pkg::GAIN_W-1:0]    gain_sh;
    logic [adnp_pkg::RATE_BITS-1:0] in_rate_sh;
    logic [adnp_pkg::RATE_BITS-1:0] out_rate_sh;
    longint                         ph_acc;
    logic [adnp_pkg::NIB_W-1:0]     held_nib;
    logic                           nib_waiting;
    logic [1:0]                     bytes_mod4;

    pcm_req_t     req_backlog[$];
    packed_byte_t bytes_due[$];
    int           n_queued   = 0;
    int           n_taken    = 0;
    int           fail_cnt   = 0;
    int           feed_gap   = 0;
    int           out_stall  = 0;
    bit           in_took    = 1'b0;
    bit           out_took   = 1'b0;
    bit           no_idle    = 1'b1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clip_phase(input longint v);
        if (v > PH_MAX)
            return PH_MAX;
        if (v < PH_MIN)
            return PH_MIN;
        return v;
    endfunction

    // Advance the model by one accepted request and queue the bytes it makes
    function automatic void pack_model(input pcm_req_t req);
        packed_byte_t               burst[$];
        packed_byte_t               pb;
        longint                     smp;
        longint                     num;
        logic [adnp_pkg::NIB_W-1:0] nib;
        if (req.cmd == adnp_pkg::CMD_FINISH)
        begin
            // flush a half-filled byte as a doubled nibble, then pad to a multiple of four bytes
            if (nib_waiting)
            begin
                pb.data = {held_nib, held_nib};
                pb.last = 1'b0;
                burst.push_back(pb);
                bytes_mod4 = bytes_mod4 + 2'd1;
            end
            while (bytes_mod4 != 2'd0)
            begin
                pb.data = adnp_pkg::PAD_BYTE;
                pb.last = 1'b0;
                burst.push_back(pb);
                bytes_mod4 = bytes_mod4 + 2'd1;
            end
            if (burst.size() != 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[k])
                bytes_due.push_back(burst[k]);
            ph_acc      = -longint'(in_rate_sh);
            held_nib    = '0;
            nib_waiting = 1'b0;
            return;
        end

        smp = longint'(req.lsmp);
        if (stereo_sh)
            smp = (smp + longint'(req.rsmp)) / 2;

        // decimate: keep the sample only when the phase turns positive
        ph_acc = clip_phase(ph_acc + longint'(out_rate_sh));
        if (ph_acc <= 0)
            return;
        ph_acc = clip_phase(ph_acc - longint'(in_rate_sh));

        // scale, offset by one half and keep the top nibble, clamped
        num = smp * longint'(gain_sh) + (longint'(1) << 31);
        if (num <= 0)
            nib = '0;
        else if ((num >>> adnp_pkg::QUANT_SHIFT) > longint'(adnp_pkg::NIB_MAX))
            nib = adnp_pkg::NIB_MAX;
        else
            nib = adnp_pkg::NIB_W'(num >>> adnp_pkg::QUANT_SHIFT);

        if (!nib_waiting)
        begin
            held_nib    = nib;
            nib_waiting = 1'b1;
        end
        else
        begin
            pb.data = {held_nib, nib};
            pb.last = 1'b1;
            bytes_due.push_back(pb);
            nib_waiting = 1'b0;
            bytes_mod4  = bytes_mod4 + 2'd1;
        end
    endfunction

    // Sample both channels, check results, and feed accepted requests to the model
    always @(posedge clk)
    begin : watch
        packed_byte_t want;
        pcm_req_t     got;
        if (rst_n)
        begin
            in_took  = in_ch.valid && in_ch.ready;
            out_took = out_ch.valid && out_ch.ready;
            if (out_took)
            begin
                if (bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected byte: expected none, got %02h last %0b",
                             $time, out_ch.out_byte, out_ch.last);
                    fail_cnt++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (out_ch.out_byte !== want.data)
                    begin
                        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, out_ch.out_byte);
                        fail_cnt++;
                    end
                    if (out_ch.last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, out_ch.last);
                        fail_cnt++;
                    end
                end
            end
            if (in_took)
            begin
                got.cmd  = in_ch.cmd;
                got.lsmp = in_ch.left_sample;
                got.rsmp = in_ch.right_sample;
                pack_model(got);
                n_taken++;
            end
        end
    end

    // Present queued requests, hold each until taken, then idle for a drawn gap
    always @(negedge clk)
    begin : feed
        pcm_req_t nxt;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_took)
        begin
            if (feed_gap > 0)
            begin
                feed_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (req_backlog.size() != 0)
            begin
                nxt = req_backlog.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.cmd          <= nxt.cmd;
                in_ch.left_sample  <= nxt.lsmp;
                in_ch.right_sample <= nxt.rsmp;
                feed_gap = no_idle ? 0 : $urandom_range(0, 10);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Stall the byte channel for a drawn number of cycles after each byte
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_took)
                out_stall = no_idle ? 0 : $urandom_range(0, 10);
            if (out_stall > 0)
            begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic queue_req(input logic cmd,
                             input logic signed [adnp_pkg::SAMPLE_W-1:0] l,
                             input logic signed [adnp_pkg::SAMPLE_W-1:0] r);
        pcm_req_t req;
        req.cmd  = cmd;
        req.lsmp = l;
        req.rsmp = r;
        req_backlog.push_back(req);
        n_queued++;
    endtask

    task automatic queue_finish();
        queue_req(adnp_pkg::CMD_FINISH, adnp_pkg::SAMPLE_W'($urandom),
                  adnp_pkg::SAMPLE_W'($urandom));
    endtask

    // Wait until every request is taken and every byte is back, then let the pipe empty
    task automatic settle();
        while (n_taken != n_queued || bytes_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [adnp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [adnp_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            adnp_pkg::REG_STEREO:   stereo_sh = val[0];
            adnp_pkg::REG_GAIN:     gain_sh = val[adnp_pkg::GAIN_W-1:0];
            adnp_pkg::REG_IN_RATE:
            begin
                in_rate_sh = val[adnp_pkg::RATE_BITS-1:0];
                ph_acc     = -longint'(in_rate_sh);
            end
            adnp_pkg::REG_OUT_RATE: out_rate_sh = val[adnp_pkg::RATE_BITS-1:0];
            default:                ;
        endcase
    endtask

    function automatic logic signed [adnp_pkg::SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return adnp_pkg::SAMPLE_W'($urandom_range(0, 512)) - 16'sd256;
            default: return adnp_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [adnp_pkg::CFG_W-1:0]     g;
        logic [adnp_pkg::RATE_BITS-1:0] ir;
        logic [adnp_pkg::RATE_BITS-1:0] orr;
        case ($urandom_range(0, 4))
            0:       g = '0;
            1:       g = adnp_pkg::CFG_W'(GAIN_MAX);
            2:       g = adnp_pkg::CFG_W'(adnp_pkg::GAIN_RST);
            3:       g = adnp_pkg::CFG_W'($urandom_range(0, 4 * adnp_pkg::GAIN_RST));
            default: g = adnp_pkg::CFG_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       ir = adnp_pkg::RATE_BITS'(1);
            1:       ir = RATE_MAX;
            default: ir = adnp_pkg::RATE_BITS'($urandom_range(1, RATE_MAX));
        endcase
        // mostly mild decimation so bytes come often; sometimes upsample
        case ($urandom_range(0, 5))
            0:       orr = ir;
            1:       orr = RATE_MAX;
            default: orr = adnp_pkg::RATE_BITS'($urandom_range(ir / 3 + 1, ir));
        endcase
        write_reg(adnp_pkg::REG_STEREO, adnp_pkg::CFG_W'($urandom_range(0, 1)));
        write_reg(adnp_pkg::REG_GAIN, g);
        write_reg(adnp_pkg::REG_OUT_RATE, adnp_pkg::CFG_W'(orr));
        write_reg(adnp_pkg::REG_IN_RATE, adnp_pkg::CFG_W'(ir));
    endtask

    // Mostly whole streams ending in a finish, with stray finishes mixed in
    task automatic random_phase(input int n_items, input bit pause_mid);
        int made;
        int len;
        made = 0;
        while (made < n_items)
        begin
            if (pause_mid && made >= n_items / 2)
            begin
                settle();
                pause_mid = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                queue_finish();
                made++;
            end
            else
            begin
                len = $urandom_range(1, 14);
                repeat (len)
                begin
                    queue_req(adnp_pkg::CMD_SAMPLE, draw_sample(), draw_sample());
                    made++;
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    queue_finish();
                    made++;
                end
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = adnp_pkg::REG_STEREO;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = adnp_pkg::CMD_SAMPLE;
        in_ch.left_sample  = '0;
        in_ch.right_sample = '0;
        out_ch.ready       = 1'b0;
        stereo_sh          = 1'b0;
        gain_sh            = adnp_pkg::GAIN_W'(adnp_pkg::GAIN_RST);
        in_rate_sh         = adnp_pkg::RATE_BITS'(adnp_pkg::IN_RATE_RST);
        out_rate_sh        = adnp_pkg::RATE_BITS'(adnp_pkg::OUT_RATE_RST);
        ph_acc             = -longint'(adnp_pkg::IN_RATE_RST);
        held_nib           = '0;
        nib_waiting        = 1'b0;
        bytes_mod4         = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: the sixth sample is the first kept, finish doubles it
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sh7FFF, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd32768, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd0, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd1000, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd1000, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd12345, 16'sd0);
        queue_finish();
        settle();

        // keep every sample after the first: extremes, zero, minus one; finish pads, then a bare finish
        no_idle = 1'b0;
        write_reg(adnp_pkg::REG_STEREO, adnp_pkg::CFG_W'(0));
        write_reg(adnp_pkg::REG_GAIN, adnp_pkg::CFG_W'(adnp_pkg::GAIN_RST));
        write_reg(adnp_pkg::REG_OUT_RATE, adnp_pkg::CFG_W'(1));
        write_reg(adnp_pkg::REG_IN_RATE, adnp_pkg::CFG_W'(1));
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd0, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd32768, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sh7FFF, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd0, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd1, 16'sd0);
        queue_finish();
        queue_finish();
        settle();

        // stereo averaging with odd sums, at full gain; the first pair, of opposite signs, is not kept
        write_reg(adnp_pkg::REG_STEREO, adnp_pkg::CFG_W'(1));
        write_reg(adnp_pkg::REG_GAIN, adnp_pkg::CFG_W'(GAIN_MAX));
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sh7FFF, -16'sd32768);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd3, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd32768, -16'sd32768);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF);
        queue_finish();
        settle();

        // zero gain puts every kept sample at mid scale
        write_reg(adnp_pkg::REG_GAIN, adnp_pkg::CFG_W'(0));
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sh1234, -16'sd5);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd32768, 16'sh7FFF);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sh7FFF, 16'sd1);
        queue_finish();
        settle();

        // upsample until the phase saturates, leaving the stream open
        no_idle = 1'b1;
        write_reg(adnp_pkg::REG_GAIN, adnp_pkg::CFG_W'(adnp_pkg::GAIN_RST));
        write_reg(adnp_pkg::REG_OUT_RATE, adnp_pkg::CFG_W'(RATE_MAX));
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd100, 16'sd200);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd4000, 16'sd300);
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd9000, -16'sd9000);
        settle();

        // zero output rate keeps while the phase is > 0; an index past the last register is ignored
        write_reg(adnp_pkg::REG_OUT_RATE, adnp_pkg::CFG_W'(0));
        write_reg(REG_UNUSED, adnp_pkg::CFG_W'(GAIN_MAX));
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd2222, 16'sd0);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd2222, 16'sd0);
        queue_finish();
        settle();

        // zero input rate keeps every sample
        write_reg(adnp_pkg::REG_IN_RATE, adnp_pkg::CFG_W'(0));
        write_reg(adnp_pkg::REG_OUT_RATE, adnp_pkg::CFG_W'(5));
        queue_req(adnp_pkg::CMD_SAMPLE, 16'sd7, 16'sd9);
        queue_req(adnp_pkg::CMD_SAMPLE, -16'sd8192, 16'sd8191);
        queue_finish();
        settle();

        // random settings and streams; one phase pauses midway for a full drain
        for (int ph = 0; ph < 6; ph++)
        begin
            no_idle = (ph == 0) || ($urandom_range(0, 3) == 0);
            random_config();
            random_phase(8, ph == 2);
        end

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
